@@ design/bcomp_pkg.sv @@
// Shared types, register indexes and widths for the barometer compensation block.
package bcomp_pkg;

	// Configuration port: register index width and register indexes.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE        = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP_READING = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_BIAS    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_PARAMS     = 4'd7;

	// Number of register stages from an accepted reading to its result.
	localparam int LATENCY = 9;

	// Internal datapath widths.
	localparam int D_W    = 17; // temperature difference, signed
	localparam int SQ_W   = 32; // squared difference
	localparam int PROD_W = 40; // squared difference times curve gain
	localparam int DUT_W  = 36; // corrected temperature difference, Q8
	localparam int MUL_W  = 53; // coefficient products
	localparam int SENS_W = 44; // sensitivity, Q8
	localparam int OFF_W  = 42; // offset, Q8 times four
	localparam int X_W    = 62; // pressure numerator
	localparam int T_W    = 58; // temperature numerator
	localparam int PN_W   = 64; // scaled pressure numerator

	// Arithmetic constants.
	localparam int MAX_SHIFT   = 31;
	localparam int D1_OFFSET   = 7168;
	localparam int OFF_COEF_0  = 1024;
	localparam longint TEMP_BASE = 64'd41943040000; // 2500 * 2^24
	localparam int TEMP_MAX    = 32767;
	localparam int TEMP_MIN    = -32768;
	localparam int PRES_MAX    = 8388607;
	localparam int PRES_MIN    = -8388608;

	// One raw reading pair.
	typedef struct packed {
		logic [15:0] pressure_reading;
		logic [15:0] temperature_reading;
	} reading_t;

	// One compensated result.
	typedef struct packed {
		logic signed [23:0] pressure_centi_hpa;
		logic signed [15:0] temperature_centi_c;
	} result_t;

	// Calibration register file as seen by the datapath.
	typedef struct packed {
		logic [15:0] sens_base;
		logic [15:0] offset_base;
		logic [15:0] sens_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] ref_temp_reading;
		logic [15:0] temp_slope;
		logic [15:0] pressure_bias;
		logic [31:0] curve_params;
	} cal_t;

endpackage

@@ design/bcomp_pipe.sv @@
// Nine-stage compensation datapath: one reading pair in and one result out per cycle.
module bcomp_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  bcomp_pkg::reading_t reading,
	input  bcomp_pkg::cal_t     cal,
	output logic               out_valid,
	output bcomp_pkg::result_t  result
);

	localparam int D_W    = bcomp_pkg::D_W;
	localparam int SQ_W   = bcomp_pkg::SQ_W;
	localparam int PROD_W = bcomp_pkg::PROD_W;
	localparam int DUT_W  = bcomp_pkg::DUT_W;
	localparam int MUL_W  = bcomp_pkg::MUL_W;
	localparam int SENS_W = bcomp_pkg::SENS_W;
	localparam int OFF_W  = bcomp_pkg::OFF_W;
	localparam int X_W    = bcomp_pkg::X_W;
	localparam int T_W    = bcomp_pkg::T_W;
	localparam int PN_W   = bcomp_pkg::PN_W;

	localparam logic [MUL_W-1:0] RND10 = MUL_W'((1 << 10) - 1);
	localparam logic [MUL_W-1:0] RND14 = MUL_W'((1 << 14) - 1);
	localparam logic [T_W-1:0]   RND24 = T_W'((1 << 24) - 1);
	localparam logic [PN_W-1:0]  RND25 = PN_W'((1 << 25) - 1);

	// Curve parameter fields; shift counts above the limit are clamped.
	logic [7:0] gain_a_c;
	logic [7:0] gain_b_c;
	logic [4:0] sc_c;
	logic [4:0] sd_c;

	assign gain_a_c = cal.curve_params[31:24];
	assign gain_b_c = cal.curve_params[23:16];
	assign sc_c = (cal.curve_params[15:8] > 8'(bcomp_pkg::MAX_SHIFT)) ?
		5'(bcomp_pkg::MAX_SHIFT) : cal.curve_params[12:8];
	assign sd_c = (cal.curve_params[7:0] > 8'(bcomp_pkg::MAX_SHIFT)) ?
		5'(bcomp_pkg::MAX_SHIFT) : cal.curve_params[4:0];

	// Stage 1: temperature difference and its square.
	logic signed [D_W-1:0] d_c;
	logic [15:0]           absd_c;
	logic [SQ_W-1:0]       sq_c;

	assign d_c = $signed({1'b0, reading.temperature_reading}) -
		$signed({1'b0, cal.ref_temp_reading});
	assign absd_c = d_c[D_W-1] ? 16'(-d_c) : d_c[15:0];
	assign sq_c = 32'(absd_c) * 32'(absd_c);

	logic                  v_s1;
	logic signed [D_W-1:0] d_s1;
	logic [SQ_W-1:0]       sq_s1;
	logic [15:0]           d1_s1;

	// Stage 2: square times the gain picked by the sign of the difference.
	logic [7:0]        gain_c;
	logic [PROD_W-1:0] prod_c;

	assign gain_c = d_s1[D_W-1] ? gain_b_c : gain_a_c;
	assign prod_c = 40'(sq_s1) * 40'(gain_c);

	logic                  v_s2;
	logic signed [D_W-1:0] d_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic [15:0]           d1_s2;

	// Stage 3: quadratic correction; the Q8 scale folds into the shift.
	logic [5:0]              csh_c;
	logic [PROD_W-1:0]       corr_c;
	logic signed [DUT_W-1:0] d256_c;
	logic signed [DUT_W-1:0] dut_c;

	assign csh_c  = 6'd6 + 6'(sc_c);
	assign corr_c = prod_s2 >> csh_c;
	assign d256_c = $signed({{11{d_s2[D_W-1]}}, d_s2, 8'b0});
	assign dut_c  = d256_c - $signed({1'b0, corr_c[34:0]});

	logic                    v_s3;
	logic signed [DUT_W-1:0] dut_s3;
	logic [15:0]             d1_s3;

	// Stage 4: the three coefficient products.
	logic signed [D_W-1:0]   c3s_c;
	logic signed [D_W-1:0]   c4m_c;
	logic signed [D_W-1:0]   c6s_c;
	logic signed [MUL_W-1:0] msens_c;
	logic signed [MUL_W-1:0] moff_c;
	logic signed [MUL_W-1:0] mtmp_c;

	assign c3s_c = $signed({1'b0, cal.sens_temp_coeff});
	assign c4m_c = $signed({1'b0, cal.offset_temp_coeff}) - D_W'(bcomp_pkg::OFF_COEF_0);
	assign c6s_c = $signed({1'b0, cal.temp_slope});
	assign msens_c = MUL_W'(c3s_c) * MUL_W'(dut_s3);
	assign moff_c  = MUL_W'(c4m_c) * MUL_W'(dut_s3);
	assign mtmp_c  = MUL_W'(c6s_c) * MUL_W'(dut_s3);

	logic                    v_s4;
	logic signed [MUL_W-1:0] msens_s4;
	logic signed [MUL_W-1:0] moff_s4;
	logic signed [MUL_W-1:0] mtmp_s4;
	logic signed [DUT_W-1:0] dut_s4;
	logic [15:0]             d1_s4;

	// Stage 5: sensitivity, offset and the two temperature terms.
	logic signed [MUL_W-1:0]  msens_t_c;
	logic signed [MUL_W-1:0]  moff_t_c;
	logic signed [SENS_W-1:0] sens_c;
	logic signed [OFF_W-1:0]  off_c;
	logic signed [T_W-1:0]    tm_c;
	logic signed [T_W-1:0]    tmul_c;
	logic signed [T_W-1:0]    dx_c;
	logic signed [T_W-1:0]    dbig_c;
	logic [T_W-1:0]           tmask_c;
	logic signed [T_W-1:0]    tsub_c;
	logic signed [D_W-1:0]    d1m_c;

	assign msens_t_c = $signed(msens_s4 + (msens_s4[MUL_W-1] ? RND10 : MUL_W'(0))) >>> 10;
	assign moff_t_c  = $signed(moff_s4 + (moff_s4[MUL_W-1] ? RND14 : MUL_W'(0))) >>> 14;
	assign sens_c = SENS_W'(msens_t_c + $signed({29'b0, cal.sens_base, 8'b0}));
	assign off_c  = OFF_W'((moff_t_c + $signed({29'b0, cal.offset_base, 8'b0})) <<< 2);
	assign tm_c   = T_W'(mtmp_s4);
	assign tmul_c = (tm_c <<< 3) + (tm_c <<< 1);
	assign dx_c   = T_W'(dut_s4);
	assign dbig_c = (dx_c <<< 19) + (dx_c <<< 17);
	assign tmask_c = (T_W'(1) << sd_c) - T_W'(1);
	assign tsub_c = $signed(dbig_c + (dbig_c[T_W-1] ? tmask_c : T_W'(0))) >>> sd_c;
	assign d1m_c  = $signed({1'b0, d1_s4}) - D_W'(bcomp_pkg::D1_OFFSET);

	logic                     v_s5;
	logic signed [SENS_W-1:0] sens_s5;
	logic signed [OFF_W-1:0]  off_s5;
	logic signed [T_W-1:0]    tmul_s5;
	logic signed [T_W-1:0]    tsub_s5;
	logic signed [D_W-1:0]    d1m_s5;

	// Stage 6: sensitivity times the pressure reading; temperature numerator.
	logic signed [X_W-1:0] xa_c;
	logic signed [X_W-1:0] offsh_c;
	logic signed [T_W-1:0] tn_c;

	assign xa_c    = X_W'(sens_s5) * X_W'(d1m_s5);
	assign offsh_c = X_W'(off_s5) <<< 14;
	assign tn_c    = $signed(T_W'(bcomp_pkg::TEMP_BASE)) + tmul_s5 - tsub_s5;

	logic                  v_s6;
	logic signed [X_W-1:0] xa_s6;
	logic signed [X_W-1:0] offsh_s6;
	logic signed [T_W-1:0] tn_s6;

	// Stage 7: pressure numerator; temperature scaled down and saturated.
	logic signed [X_W-1:0] xn_c;
	logic signed [T_W-1:0] tq_c;
	logic signed [15:0]    tsat_c;

	assign xn_c = xa_s6 - offsh_s6;
	assign tq_c = $signed(tn_s6 + (tn_s6[T_W-1] ? RND24 : T_W'(0))) >>> 24;

	always_comb begin
		if (tq_c > T_W'(bcomp_pkg::TEMP_MAX)) begin
			tsat_c = 16'(bcomp_pkg::TEMP_MAX);
		end else if (tq_c < T_W'(bcomp_pkg::TEMP_MIN)) begin
			tsat_c = 16'(bcomp_pkg::TEMP_MIN);
		end else begin
			tsat_c = tq_c[15:0];
		end
	end

	logic                  v_s7;
	logic signed [X_W-1:0] xn_s7;
	logic signed [15:0]    t_s7;

	// Stage 8: times 25 by shifts, plus the output bias.
	logic [19:0]            c7x10_c;
	logic signed [PN_W-1:0] bias_c;
	logic signed [PN_W-1:0] x64_c;
	logic signed [PN_W-1:0] pn_c;

	assign c7x10_c = 20'({cal.pressure_bias, 3'b0}) + 20'({cal.pressure_bias, 1'b0});
	assign bias_c  = $signed({19'b0, c7x10_c, 25'b0});
	assign x64_c   = PN_W'(xn_s7);
	assign pn_c    = (x64_c <<< 4) + (x64_c <<< 3) + x64_c + bias_c;

	logic                   v_s8;
	logic signed [PN_W-1:0] pn_s8;
	logic signed [15:0]     t_s8;

	// Stage 9: pressure scaled down and saturated into the output register.
	logic signed [PN_W-1:0] pq_c;
	logic signed [23:0]     psat_c;

	assign pq_c = $signed(pn_s8 + (pn_s8[PN_W-1] ? RND25 : PN_W'(0))) >>> 25;

	always_comb begin
		if (pq_c > PN_W'(bcomp_pkg::PRES_MAX)) begin
			psat_c = 24'(bcomp_pkg::PRES_MAX);
		end else if (pq_c < PN_W'(bcomp_pkg::PRES_MIN)) begin
			psat_c = 24'(bcomp_pkg::PRES_MIN);
		end else begin
			psat_c = pq_c[23:0];
		end
	end

	logic                v_s9;
	bcomp_pkg::result_t  res_s9;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Payload registers load only with a valid transaction.
	always_ff @(posedge clk) begin
		if (in_valid) begin
			d_s1  <= d_c;
			sq_s1 <= sq_c;
			d1_s1 <= reading.pressure_reading;
		end
		if (v_s1) begin
			d_s2    <= d_s1;
			prod_s2 <= prod_c;
			d1_s2   <= d1_s1;
		end
		if (v_s2) begin
			dut_s3 <= dut_c;
			d1_s3  <= d1_s2;
		end
		if (v_s3) begin
			msens_s4 <= msens_c;
			moff_s4  <= moff_c;
			mtmp_s4  <= mtmp_c;
			dut_s4   <= dut_s3;
			d1_s4    <= d1_s3;
		end
		if (v_s4) begin
			sens_s5 <= sens_c;
			off_s5  <= off_c;
			tmul_s5 <= tmul_c;
			tsub_s5 <= tsub_c;
			d1m_s5  <= d1m_c;
		end
		if (v_s5) begin
			xa_s6    <= xa_c;
			offsh_s6 <= offsh_c;
			tn_s6    <= tn_c;
		end
		if (v_s6) begin
			xn_s7 <= xn_c;
			t_s7  <= tsat_c;
		end
		if (v_s7) begin
			pn_s8 <= pn_c;
			t_s8  <= t_s7;
		end
		if (v_s8) begin
			res_s9.pressure_centi_hpa  <= psat_c;
			res_s9.temperature_centi_c <= t_s8;
		end
	end

	assign out_valid = v_s9;
	assign result    = res_s9;

	// Every accepted transaction yields a result once it has passed the LATENCY register stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(bcomp_pkg::LATENCY) out_valid)
		else $error("accepted transaction produced no result");

	// No result appears without a transaction behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, bcomp_pkg::LATENCY))
		else $error("result without an accepted transaction");

	// The correction only pulls the difference down, so a negative one stays negative.
	a_neg_dut: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && d_s2[D_W-1]) |=> dut_s3[DUT_W-1])
		else $error("corrected temperature difference changed sign");

	// A zero difference gets no correction.
	a_zero_dut: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (d_s2 == '0)) |=> (dut_s3 == '0))
		else $error("zero temperature difference was corrected");

endmodule

@@ design/barometer_compensation_top.sv @@
// A reading pair accepted at a clock edge gives its result strobe after the nine register stages.
// Throughput: one reading pair per clock cycle through the nine-stage datapath, once busy is low.
// The result is shown for one cycle with done and is not held off by the receiver.
// Reset: arst_n clears the calibration registers to zero and empties the pipeline;
// busy stays high for the first cycle after reset.
module barometer_compensation_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  bcomp_pkg::reading_t                reading,
	output logic                               done,
	output bcomp_pkg::result_t                 result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bcomp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data
);

	logic            busy_q;
	bcomp_pkg::cal_t cal_q;
	logic            cfg_we;
	logic            accept;

	// Busy for one cycle after reset, then a transaction is taken in every cycle with start high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign cfg_ready = ~busy_q;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign accept    = start & ~busy_q;

	// Calibration register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bcomp_pkg::REG_SENS_BASE:        cal_q.sens_base <= cfg_data[15:0];
				bcomp_pkg::REG_OFFSET_BASE:      cal_q.offset_base <= cfg_data[15:0];
				bcomp_pkg::REG_SENS_TEMP_COEFF:  cal_q.sens_temp_coeff <= cfg_data[15:0];
				bcomp_pkg::REG_OFFSET_TEMP_COEF: cal_q.offset_temp_coeff <= cfg_data[15:0];
				bcomp_pkg::REG_REF_TEMP_READING: cal_q.ref_temp_reading <= cfg_data[15:0];
				bcomp_pkg::REG_TEMP_SLOPE:       cal_q.temp_slope <= cfg_data[15:0];
				bcomp_pkg::REG_PRESSURE_BIAS:    cal_q.pressure_bias <= cfg_data[15:0];
				bcomp_pkg::REG_CURVE_PARAMS:     cal_q.curve_params <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Compensation datapath.
	bcomp_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.reading   (reading),
		.cal       (cal_q),
		.out_valid (done),
		.result    (result)
	);

endmodule

@@ test/barometer_compensation_top_tb.sv @@
// Self-checking testbench for the barometer compensation block with an in-bench predictor.
`timescale 1ns / 100ps

module barometer_compensation_top_tb;

	localparam int PHASES         = 10;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int REPORT_LIMIT   = 10;

	// Calibration sets used by the directed rows.
	typedef enum int {
		CAL_RESET,
		CAL_ALL_MAX,
		CAL_STEEP_CURVE,
		CAL_WIDE_SHIFT
	} dir_cal_t;

	// One directed row: which calibration, the readings, and an optional typed-in result.
	typedef struct {
		dir_cal_t            cal_sel;
		bcomp_pkg::reading_t rd;
		bit                  typed;
		bcomp_pkg::result_t  res;
	} dir_row_t;

	// One expected compensation, kept with its readings for reporting.
	typedef struct {
		bcomp_pkg::reading_t rd;
		bcomp_pkg::result_t  res;
	} comp_entry_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	bcomp_pkg::reading_t             reading;
	logic                            done;
	bcomp_pkg::result_t              result;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                     cfg_data;

	bcomp_pkg::cal_t    cal_shadow;
	comp_entry_t        awaiting_comp[$];
	dir_row_t           directed_rows[$];
	int                 mismatch_count;
	int unsigned        gap_pct;
	bit                 typed_valid;
	bcomp_pkg::result_t typed_res;

	barometer_compensation_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.reading   (reading),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog in case the block hangs.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Compensated pressure and temperature for one reading pair under a calibration set.
	function automatic bcomp_pkg::result_t compensate(input bcomp_pkg::cal_t c,
		input bcomp_pkg::reading_t rd);
		longint  d1, diff, gain, shift_c, shift_d, dut_q, sens_q, off_q, xn, p, tn, t;
		bcomp_pkg::result_t res;
		d1 = longint'(rd.pressure_reading);
		diff = longint'(rd.temperature_reading) - longint'(c.ref_temp_reading);
		gain = (diff >= 0) ? longint'(c.curve_params[31:24]) : longint'(c.curve_params[23:16]);
		shift_c = longint'(c.curve_params[15:8]);
		shift_d = longint'(c.curve_params[7:0]);
		if (shift_c > bcomp_pkg::MAX_SHIFT)
			shift_c = bcomp_pkg::MAX_SHIFT;
		if (shift_d > bcomp_pkg::MAX_SHIFT)
			shift_d = bcomp_pkg::MAX_SHIFT;

		// Quadratic correction of the temperature difference, Q8.
		dut_q = diff * 256 - (diff * diff * gain * 256) / (longint'(1) << (14 + shift_c));

		// Sensitivity and offset, then pressure.
		sens_q = longint'(c.sens_base) * 256 + (longint'(c.sens_temp_coeff) * dut_q) / 1024;
		off_q = 4 * (longint'(c.offset_base) * 256
			+ ((longint'(c.offset_temp_coeff) - bcomp_pkg::OFF_COEF_0) * dut_q) / 16384);
		xn = sens_q * (d1 - bcomp_pkg::D1_OFFSET) - off_q * 16384;
		p = (xn * 25 + longint'(c.pressure_bias) * 10 * (longint'(1) << 25))
			/ (longint'(1) << 25);
		if (p > bcomp_pkg::PRES_MAX)
			p = bcomp_pkg::PRES_MAX;
		if (p < bcomp_pkg::PRES_MIN)
			p = bcomp_pkg::PRES_MIN;

		// Temperature from the slope terms.
		tn = 2500 * (longint'(1) << 24) + dut_q * longint'(c.temp_slope) * 10
			- (dut_q * 10 * 65536) / (longint'(1) << shift_d);
		t = tn / (longint'(1) << 24);
		if (t > bcomp_pkg::TEMP_MAX)
			t = bcomp_pkg::TEMP_MAX;
		if (t < bcomp_pkg::TEMP_MIN)
			t = bcomp_pkg::TEMP_MIN;

		res.pressure_centi_hpa = 24'(p);
		res.temperature_centi_c = 16'(t);
		return res;
	endfunction

	// Calibration sets for the directed rows.
	function automatic bcomp_pkg::cal_t directed_cal(input dir_cal_t sel);
		bcomp_pkg::cal_t c;
		c.sens_base = 16'd29908;
		c.offset_base = 16'd3724;
		c.sens_temp_coeff = 16'd312;
		c.offset_temp_coeff = 16'd441;
		c.ref_temp_reading = 16'd9000;
		c.temp_slope = 16'd3990;
		c.pressure_bias = 16'd2500;
		case (sel)
			CAL_RESET: begin
				c = '0;
			end
			CAL_ALL_MAX: begin
				c = '1;
			end
			CAL_STEEP_CURVE: begin
				c.curve_params = {8'd255, 8'd1, 8'd0, 8'd0};
			end
			default: begin
				c.curve_params = {8'd1, 8'd255, 8'd32, 8'd200};
			end
		endcase
		return c;
	endfunction

	function automatic dir_row_t mk_row(input dir_cal_t sel, input int p, input int t,
		input bit typed, input int exp_p, input int exp_t);
		dir_row_t row;
		row.cal_sel = sel;
		row.rd.pressure_reading = 16'(p);
		row.rd.temperature_reading = 16'(t);
		row.typed = typed;
		row.res.pressure_centi_hpa = 24'(exp_p);
		row.res.temperature_centi_c = 16'(exp_t);
		return row;
	endfunction

	// Random calibration: plausible sensor values half the time, otherwise wild or extreme.
	function automatic bcomp_pkg::cal_t random_cal();
		bcomp_pkg::cal_t c;
		int unsigned     mode;
		mode = $urandom_range(0, 3);
		if (mode <= 1) begin
			c.sens_base = 16'($urandom_range(16000, 32000));
			c.offset_base = 16'($urandom_range(1000, 8000));
			c.sens_temp_coeff = 16'($urandom_range(50, 1000));
			c.offset_temp_coeff = 16'($urandom_range(100, 2000));
			c.ref_temp_reading = 16'($urandom_range(6000, 12000));
			c.temp_slope = 16'($urandom_range(1000, 6000));
			c.pressure_bias = 16'($urandom_range(1500, 3500));
			c.curve_params = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
				8'($urandom_range(0, 40)), 8'($urandom_range(0, 40))};
		end else if (mode == 2) begin
			c.sens_base = 16'($urandom);
			c.offset_base = 16'($urandom);
			c.sens_temp_coeff = 16'($urandom);
			c.offset_temp_coeff = 16'($urandom);
			c.ref_temp_reading = 16'($urandom);
			c.temp_slope = 16'($urandom);
			c.pressure_bias = 16'($urandom);
			c.curve_params = $urandom;
		end else begin
			// Each field at one of its ends.
			c.sens_base = $urandom_range(1) ? '1 : '0;
			c.offset_base = $urandom_range(1) ? '1 : '0;
			c.sens_temp_coeff = $urandom_range(1) ? '1 : '0;
			c.offset_temp_coeff = $urandom_range(1) ? '1 : '0;
			c.ref_temp_reading = $urandom_range(1) ? '1 : '0;
			c.temp_slope = $urandom_range(1) ? '1 : '0;
			c.pressure_bias = $urandom_range(1) ? '1 : '0;
			c.curve_params = {$urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
				$urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00};
		end
		return c;
	endfunction

	// Random readings: temperature often near the reference, pressure often in the usual band.
	function automatic bcomp_pkg::reading_t random_reading(input bcomp_pkg::cal_t c);
		bcomp_pkg::reading_t rd;
		int                  t;
		if ($urandom_range(1)) begin
			t = int'(c.ref_temp_reading) + int'($urandom_range(0, 4000)) - 2000;
			if (t < 0)
				t = 0;
			if (t > 65535)
				t = 65535;
			rd.temperature_reading = 16'(t);
		end else begin
			rd.temperature_reading = 16'($urandom);
		end
		rd.pressure_reading = $urandom_range(3) ? 16'($urandom_range(15000, 50000)) : 16'($urandom);
		return rd;
	endfunction

	// One register write transaction; the shadow copy follows the block's masking.
	task automatic write_reg(input logic [bcomp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			bcomp_pkg::REG_SENS_BASE:        cal_shadow.sens_base = data[15:0];
			bcomp_pkg::REG_OFFSET_BASE:      cal_shadow.offset_base = data[15:0];
			bcomp_pkg::REG_SENS_TEMP_COEFF:  cal_shadow.sens_temp_coeff = data[15:0];
			bcomp_pkg::REG_OFFSET_TEMP_COEF: cal_shadow.offset_temp_coeff = data[15:0];
			bcomp_pkg::REG_REF_TEMP_READING: cal_shadow.ref_temp_reading = data[15:0];
			bcomp_pkg::REG_TEMP_SLOPE:       cal_shadow.temp_slope = data[15:0];
			bcomp_pkg::REG_PRESSURE_BIAS:    cal_shadow.pressure_bias = data[15:0];
			bcomp_pkg::REG_CURVE_PARAMS:     cal_shadow.curve_params = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Write a full calibration set, with junk in the unused upper bits and one stray index.
	task automatic load_cal(input bcomp_pkg::cal_t c);
		write_reg(bcomp_pkg::REG_SENS_BASE, {16'($urandom), c.sens_base});
		write_reg(bcomp_pkg::REG_OFFSET_BASE, {16'($urandom), c.offset_base});
		write_reg(bcomp_pkg::REG_SENS_TEMP_COEFF, {16'($urandom), c.sens_temp_coeff});
		write_reg(bcomp_pkg::REG_OFFSET_TEMP_COEF, {16'($urandom), c.offset_temp_coeff});
		write_reg(bcomp_pkg::REG_REF_TEMP_READING, {16'($urandom), c.ref_temp_reading});
		write_reg(bcomp_pkg::REG_TEMP_SLOPE, {16'($urandom), c.temp_slope});
		write_reg(bcomp_pkg::REG_PRESSURE_BIAS, {16'($urandom), c.pressure_bias});
		write_reg(bcomp_pkg::REG_CURVE_PARAMS, c.curve_params);
		write_reg(bcomp_pkg::REG_CURVE_PARAMS
			+ bcomp_pkg::CFG_IDX_W'($urandom_range(1, 8)), $urandom);
	endtask

	// Present one reading pair until accepted, then maybe leave a random gap.
	task automatic send_reading(input bcomp_pkg::reading_t rd, input bit typed,
		input bcomp_pkg::result_t res);
		int unsigned gap;
		@(negedge clk);
		start <= 1'b1;
		reading <= rd;
		typed_valid = typed;
		typed_res = res;
		do @(posedge clk); while (busy !== 1'b0);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			start <= 1'b0;
			reading <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop sending and let every outstanding result come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		typed_valid = 1'b0;
		while (awaiting_comp.size() != 0)
			@(posedge clk);
		repeat (bcomp_pkg::LATENCY + 2) @(posedge clk);
	endtask

	// Compare one result with the oldest expectation.
	task automatic score_result(input bcomp_pkg::result_t got);
		comp_entry_t e;
		if (awaiting_comp.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: unexpected result p=%0d t=%0d", $time,
					got.pressure_centi_hpa, got.temperature_centi_c);
		end else begin
			e = awaiting_comp.pop_front();
			if (got.pressure_centi_hpa !== e.res.pressure_centi_hpa) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: pressure wrong for D1=%0d D2=%0d: expected %0d, got %0d",
						$time, e.rd.pressure_reading, e.rd.temperature_reading,
						e.res.pressure_centi_hpa, got.pressure_centi_hpa);
			end
			if (got.temperature_centi_c !== e.res.temperature_centi_c) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: temperature wrong for D1=%0d D2=%0d: expected %0d, got %0d",
						$time, e.rd.pressure_reading, e.rd.temperature_reading,
						e.res.temperature_centi_c, got.temperature_centi_c);
			end
		end
	endtask

	// Monitor: record accepted transactions and check returned results.
	always @(posedge clk) begin
		comp_entry_t e;
		if (arst_n === 1'b1) begin
			if (done !== 1'b0)
				score_result(result);
			if (start === 1'b1 && busy === 1'b0) begin
				e.rd = reading;
				e.res = typed_valid ? typed_res : compensate(cal_shadow, reading);
				awaiting_comp.push_back(e);
			end
		end
	end

	// Stimulus.
	initial begin
		dir_cal_t        cur_cal;
		bcomp_pkg::cal_t c;
		start = 1'b0;
		reading = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		typed_valid = 1'b0;
		typed_res = '0;
		cal_shadow = '0;
		mismatch_count = 0;
		gap_pct = 25;

		// Directed rows; with all registers at zero the results follow from D2 alone.
		directed_rows.push_back(mk_row(CAL_RESET, 0, 0, 1'b1, 0, 2500));
		directed_rows.push_back(mk_row(CAL_RESET, 65535, 0, 1'b1, 0, 2500));
		directed_rows.push_back(mk_row(CAL_RESET, 0, 1, 1'b1, 0, 2490));
		directed_rows.push_back(mk_row(CAL_RESET, 1234, 250, 1'b1, 195, 0));
		directed_rows.push_back(mk_row(CAL_RESET, 0, 65535, 1'b1, 51199,
			bcomp_pkg::TEMP_MIN));
		directed_rows.push_back(mk_row(CAL_RESET, 65535, 65535, 1'b1, 51199,
			bcomp_pkg::TEMP_MIN));
		directed_rows.push_back(mk_row(CAL_ALL_MAX, 0, 0, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_ALL_MAX, 65535, 65534, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_ALL_MAX, 65535, 65535, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_STEEP_CURVE, 30000, 8999, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_STEEP_CURVE, 30000, 9000, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_STEEP_CURVE, 30000, 9001, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_STEEP_CURVE, 0, 65535, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_STEEP_CURVE, 65535, 0, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_WIDE_SHIFT, 30000, 8000, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_WIDE_SHIFT, 30000, 10000, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_WIDE_SHIFT, 7168, 9000, 1'b0, 0, 0));
		directed_rows.push_back(mk_row(CAL_WIDE_SHIFT, 65535, 65535, 1'b0, 0, 0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: reload the registers whenever the row asks for another set.
		cur_cal = CAL_RESET;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cal_sel != cur_cal) begin
				drain();
				cur_cal = directed_rows[i].cal_sel;
				load_cal(directed_cal(cur_cal));
			end
			send_reading(directed_rows[i].rd, directed_rows[i].typed, directed_rows[i].res);
		end

		// Random part: a fresh calibration per phase, no gaps in the last phase.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			c = random_cal();
			load_cal(c);
			if (phase == PHASES - 1 || $urandom_range(0, 3) == 0)
				gap_pct = 0;
			else
				gap_pct = $urandom_range(10, 60);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_reading(random_reading(cal_shadow), 1'b0, '0);
		end

		drain();
		if (mismatch_count == 0 && awaiting_comp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
